FILE: sv/task_ready_list_scheduler_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the task ready-list scheduler
// Same-cycle and next-cycle implication forms, gated by the async reset.
// ----------------------------------------------------------------------------
`ifndef TASK_READY_LIST_SCHEDULER_CORE_ASSERT_SVH
`define TASK_READY_LIST_SCHEDULER_CORE_ASSERT_SVH

// same-cycle implication
`define TRLS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("%m: assertion failed");

// next-cycle implication
`define TRLS_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("%m: assertion failed");

`endif

FILE: sv/trls_pkg.sv
// ----------------------------------------------------------------------------
// trls_pkg
// Types, codes and helpers for the two-level bitmap task ready-list scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package trls_pkg;

	localparam int PRIO_LEVELS = 64;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 7;

	// operations
	localparam logic [2:0] OP_CREATE  = 3'd0;
	localparam logic [2:0] OP_DELETE  = 3'd1;
	localparam logic [2:0] OP_SUSPEND = 3'd2;
	localparam logic [2:0] OP_RESUME  = 3'd3;
	localparam logic [2:0] OP_START   = 3'd4;
	localparam logic [2:0] OP_SET_CUR = 3'd5;

	// status codes
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_ISR      = 3'd1;
	localparam logic [2:0] ST_EXISTS   = 3'd2;
	localparam logic [2:0] ST_NO_BLOCK = 3'd3;
	localparam logic [2:0] ST_IDLE     = 3'd4;
	localparam logic [2:0] ST_INVALID  = 3'd5;
	localparam logic [2:0] ST_MISSING  = 3'd6;
	localparam logic [2:0] ST_NOT_SUSP = 3'd7;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] CFG_LOWEST_PRIO = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] CFG_TASK_CAP    = CFG_IDX_W'(1);

	localparam logic [7:0] PRIO_CURRENT = 8'hFF;
	localparam logic [5:0] LOWEST_RST   = 6'd63;
	localparam logic [6:0] CAP_RST      = 7'd64;
	localparam logic [6:0] FREE_MAX     = 7'd127;

	typedef struct packed {
		logic [2:0] operation;
		logic [7:0] priority_req;
		logic       in_interrupt;
	} trls_in_t;

	typedef struct packed {
		logic [2:0] status;
		logic [5:0] highest_ready;
		logic       any_ready;
		logic       reschedule;
		logic [6:0] task_total;
		logic [5:0] running_priority;
	} trls_res_t;

	// lowest set bit of a byte, 0 when empty
	function automatic logic [2:0] lowest_bit8(input logic [7:0] v);
		logic [2:0] idx;
		idx = 3'd0;
		for (int i = 7; i >= 0; i--) begin
			if (v[i]) idx = 3'(i);
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

FILE: sv/task_ready_list_scheduler_core.sv
// Pipeline: an accepted item is held in the input stage; its result is registered in the result stage.
// Throughput: one item per cycle unless stalled; the only loop is the bitmap state update
// through the operation decode and the two-level priority encoder, one pass per item.
// Reset (arst_n low): bitmaps, counts, current priority and started flag clear,
// lowest priority goes to 63, free blocks go to 64, no item is held.
// ----------------------------------------------------------------------------
// task_ready_list_scheduler_core
// Two-level bitmap ready list for 64 priorities: create, delete, suspend,
// resume, start and set-current requests with a registered result per item.
// ----------------------------------------------------------------------------
`default_nettype none

module task_ready_list_scheduler_core
	import trls_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_stall,
	input  wire trls_in_t              in_item,
	output logic                       res_valid,
	input  wire logic                  res_stall,
	output trls_res_t                  res_item,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	`include "task_ready_list_scheduler_core_assert.svh"

	// input stage
	logic      s1_valid_q;
	trls_in_t  item_s1;
	logic      advance;
	logic      in_accept;

	// result stage
	logic      res_valid_q;
	trls_res_t res_q;

	// configuration and scheduler state
	logic [5:0]       lowest_q;
	logic [7:0][7:0]  ready_q;
	logic [63:0]      exists_q;
	logic [63:0]      susp_q;
	logic [6:0]       free_q;
	logic [6:0]       task_cnt_q;
	logic [5:0]       cur_q;
	logic             started_q;

	// next state
	logic [7:0][7:0]  ready_d;
	logic [63:0]      exists_d;
	logic [63:0]      susp_d;
	logic [6:0]       free_d;
	logic [6:0]       task_cnt_d;
	logic [5:0]       cur_d;
	logic             started_d;
	logic [2:0]       status;
	logic             resched;
	logic [7:0]       group_q;
	logic [7:0]       group_d;
	logic [5:0]       top_q;
	logic [5:0]       top_d;

	assign advance   = s1_valid_q && (!res_valid_q || !res_stall);
	assign in_stall  = s1_valid_q && !advance;
	assign in_accept = in_valid && !in_stall;
	// hold register writes while an item waits in the input stage
	assign cfg_ready = !s1_valid_q;
	assign res_valid = res_valid_q;
	assign res_item  = res_q;

	// group bits follow the rows; a row's group bit is set exactly when the row is non-empty
	always_comb begin
		for (int r = 0; r < 8; r++) begin
			group_q[r] = |ready_q[r];
			group_d[r] = |ready_d[r];
		end
	end

	assign top_q = (group_q == 8'd0) ? 6'd0 :
		{lowest_bit8(group_q), lowest_bit8(ready_q[lowest_bit8(group_q)])};
	assign top_d = (group_d == 8'd0) ? 6'd0 :
		{lowest_bit8(group_d), lowest_bit8(ready_d[lowest_bit8(group_d)])};

	always_comb begin
		logic [7:0] p;
		logic       isr;
		logic       p_self;
		logic       p_ok;
		logic [7:0] lp8;
		logic [5:0] tgt;
		logic [5:0] p6;

		p      = item_s1.priority_req;
		isr    = item_s1.in_interrupt;
		p_self = (p == PRIO_CURRENT);
		p_ok   = (p < 8'(PRIO_LEVELS));
		lp8    = {2'b00, lowest_q};
		p6     = p[5:0];
		tgt    = p_self ? cur_q : p6;

		ready_d    = ready_q;
		exists_d   = exists_q;
		susp_d     = susp_q;
		free_d     = free_q;
		task_cnt_d = task_cnt_q;
		cur_d      = cur_q;
		started_d  = started_q;
		status     = ST_OK;
		resched    = 1'b0;

		unique case (item_s1.operation)
			OP_CREATE: begin
				if (isr) begin
					status = ST_ISR;
				end else if (p > lp8 || !p_ok) begin
					status = ST_INVALID;
				end else if (exists_q[p6]) begin
					status = ST_EXISTS;
				end else if (free_q == 7'd0) begin
					status = ST_NO_BLOCK;
				end else begin
					exists_d[p6]           = 1'b1;
					susp_d[p6]             = 1'b0;
					ready_d[p6[5:3]][p6[2:0]] = 1'b1;
					task_cnt_d             = task_cnt_q + 7'd1;
					free_d                 = free_q - 7'd1;
					resched                = started_q;
				end
			end
			OP_DELETE: begin
				if (isr) begin
					status = ST_ISR;
				end else if (p == lp8) begin
					status = ST_IDLE;
				end else if ((p >= lp8 || !p_ok) && !p_self) begin
					status = ST_INVALID;
				end else if (!exists_q[tgt]) begin
					status = ST_MISSING;
				end else begin
					ready_d[tgt[5:3]][tgt[2:0]] = 1'b0;
					exists_d[tgt] = 1'b0;
					susp_d[tgt]   = 1'b0;
					if (task_cnt_q != 7'd0) task_cnt_d = task_cnt_q - 7'd1;
					if (free_q != FREE_MAX) free_d = free_q + 7'd1;
					resched = started_q;
				end
			end
			OP_SUSPEND: begin
				if (p == lp8) begin
					status = ST_IDLE;
				end else if ((p >= lp8 || !p_ok) && !p_self) begin
					status = ST_INVALID;
				end else if (!exists_q[tgt]) begin
					status = ST_MISSING;
				end else begin
					ready_d[tgt[5:3]][tgt[2:0]] = 1'b0;
					susp_d[tgt] = 1'b1;
					resched     = (tgt == cur_q);
				end
			end
			OP_RESUME: begin
				if (p >= lp8 || !p_ok) begin
					status = ST_INVALID;
				end else if (!exists_q[p6]) begin
					status = ST_MISSING;
				end else if (!susp_q[p6]) begin
					status = ST_NOT_SUSP;
				end else begin
					susp_d[p6] = 1'b0;
					ready_d[p6[5:3]][p6[2:0]] = 1'b1;
					resched = started_q;
				end
			end
			OP_START: begin
				if (!started_q) begin
					cur_d     = top_q;
					started_d = 1'b1;
					resched   = 1'b1;
				end
			end
			OP_SET_CUR: begin
				if (!p_self) begin
					if (!p_ok) status = ST_INVALID;
					else cur_d = p6;
				end
			end
			default: begin
				status = ST_INVALID;
			end
		endcase
	end

	// control and scheduler state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			res_valid_q <= 1'b0;
			lowest_q    <= LOWEST_RST;
			ready_q     <= '0;
			exists_q    <= '0;
			susp_q      <= '0;
			free_q      <= CAP_RST;
			task_cnt_q  <= 7'd0;
			cur_q       <= 6'd0;
			started_q   <= 1'b0;
		end else begin
			s1_valid_q <= in_accept || (s1_valid_q && !advance);
			if (advance) begin
				res_valid_q <= 1'b1;
				ready_q     <= ready_d;
				exists_q    <= exists_d;
				susp_q      <= susp_d;
				free_q      <= free_d;
				task_cnt_q  <= task_cnt_d;
				cur_q       <= cur_d;
				started_q   <= started_d;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end
			// a write only lands while the input stage is empty, so never with advance
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == CFG_LOWEST_PRIO) begin
					lowest_q <= cfg_data[5:0];
				end else if (cfg_index == CFG_TASK_CAP) begin
					free_q <= (cfg_data > task_cnt_q) ? cfg_data - task_cnt_q : 7'd0;
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (in_accept) item_s1 <= in_item;
		if (advance) begin
			res_q.status           <= status;
			res_q.highest_ready    <= top_d;
			res_q.any_ready        <= (group_d != 8'd0);
			res_q.reschedule       <= resched;
			res_q.task_total       <= task_cnt_d;
			res_q.running_priority <= cur_d;
		end
	end

	`TRLS_ASSERT_IMP(a_cnt_matches_exists, clk, arst_n, 1'b1, task_cnt_q == 7'($countones(exists_q)))
	`TRLS_ASSERT_IMP(a_ready_needs_exists, clk, arst_n, 1'b1, (ready_q & ~exists_q) == 64'd0)
	`TRLS_ASSERT_IMP(a_susp_not_ready, clk, arst_n, 1'b1, (susp_q & (ready_q | ~exists_q)) == 64'd0)
	`TRLS_ASSERT_NXT(a_started_sticks, clk, arst_n, started_q, started_q)
	`TRLS_ASSERT_IMP(a_stall_full, clk, arst_n, in_stall, res_valid_q && res_stall && s1_valid_q)
	`TRLS_ASSERT_NXT(a_res_hold, clk, arst_n, res_valid_q && res_stall, res_valid_q && $stable(res_q))

endmodule

`default_nettype wire
